/* rtl/mtpl_pkg.sv */
// ----------------------------------------------------------------------------
// mtpl_pkg
// Shared types, constants and helpers of the multibit trie port lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package mtpl_pkg;

  // Table size and walk depth.
  localparam int NODES   = 256;
  localparam int LEVELS  = 4;
  localparam int IDX_W   = $clog2(NODES);
  localparam int DEPTH_W = $clog2(LEVELS + 1);

  // Stride registers.
  localparam int NUM_CFG    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int STRIDE_MAX = 8;
  localparam logic [NUM_CFG-1:0][CFG_DATA_W-1:0] STRIDE_RESET =
    {4'd3, 4'd2, 4'd2, 4'd5};

  // Request kinds.
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] dest_address;
    logic [7:0]  entry_index;
    logic [6:0]  entry_port;
    logic        entry_leaf;
    logic        entry_valid;
    logic [7:0]  entry_child_base;
  } mtpl_req_t;

  typedef struct packed {
    logic [6:0] out_port;
    logic [2:0] levels_descended;
    logic       reached_leaf;
  } mtpl_res_t;

  typedef struct packed {
    logic       valid;
    logic       leaf;
    logic [6:0] port;
    logic [7:0] child_base;
  } mtpl_node_t;

  localparam int NODE_W = $bits(mtpl_node_t);

  // Write request into the node store.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    mtpl_node_t       node;
  } mtpl_wr_t;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } mtpl_state_t;

  // Reduces a nine-bit table index modulo NODES.
  function automatic logic [IDX_W-1:0] to_idx(input logic [8:0] v);
    logic [IDX_W+8:0] w;
    w = (IDX_W+9)'(v);
    return w[IDX_W-1:0];
  endfunction

  // Keeps the low three bits of a descent count.
  function automatic logic [2:0] to_levels(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W+2:0] w;
    w = (DEPTH_W+3)'(d);
    return w[2:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/mtpl_ram.sv */
// ----------------------------------------------------------------------------
// mtpl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/mtpl_node_store.sv */
// ----------------------------------------------------------------------------
// mtpl_node_store
// Node table: RAM plus one written flag per entry, so that entries never
// written since reset read as all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpl_node_store (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mtpl_pkg::mtpl_wr_t             wr,
  input  wire logic [mtpl_pkg::IDX_W-1:0]     rd_addr,
  output mtpl_pkg::mtpl_node_t                rd_node
);

  import mtpl_pkg::*;

  logic [NODES-1:0]  written;
  logic              rd_written;
  logic [NODE_W-1:0] ram_q;

  mtpl_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.idx),
    .wdata (wr.node),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  assign rd_node = rd_written ? mtpl_node_t'(ram_q) : '0;

endmodule

`default_nettype wire

/* rtl/mtpl_chunk.sv */
// ----------------------------------------------------------------------------
// mtpl_chunk
// Address shift unit: extracts the next chunk from the top of the remaining
// address and shifts the consumed bits out.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpl_chunk (
  input  wire logic [31:0]                       addr_sh,
  input  wire logic [mtpl_pkg::CFG_DATA_W-1:0]   stride_raw,
  output logic      [7:0]                        chunk,
  output logic      [31:0]                       addr_next
);

  import mtpl_pkg::*;

  logic [CFG_DATA_W-1:0] stride;

  // Strides above the maximum saturate.
  assign stride = (stride_raw > CFG_DATA_W'(STRIDE_MAX)) ? CFG_DATA_W'(STRIDE_MAX)
                                                         : stride_raw;

  // A stride of zero shifts the whole byte away and yields a zero chunk.
  assign chunk     = addr_sh[31:24] >> (CFG_DATA_W'(STRIDE_MAX) - stride);
  assign addr_next = addr_sh << stride;

endmodule

`default_nettype wire

/* rtl/mtpl_seq.sv */
// ----------------------------------------------------------------------------
// mtpl_seq
// Walk sequencer: evaluates one node per cycle, computes the next child
// index with the shared shift unit and issues the next table read.
// ----------------------------------------------------------------------------
`default_nettype none

module mtpl_seq (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          go,
  input  wire logic [31:0]                                   dest_address,
  input  wire logic [mtpl_pkg::NUM_CFG-1:0][mtpl_pkg::CFG_DATA_W-1:0] strides,
  input  wire mtpl_pkg::mtpl_node_t                          rd_node,
  output logic      [mtpl_pkg::IDX_W-1:0]                    rd_addr,
  output logic                                               busy,
  output logic                                               done,
  output mtpl_pkg::mtpl_res_t                                result
);

  import mtpl_pkg::*;

  mtpl_state_t           state, state_next;
  logic [DEPTH_W-1:0]    depth;
  logic [31:0]           addr_sh;
  logic [6:0]            cur_port;

  logic [CFG_DATA_W-1:0] stride_sel;
  logic [7:0]            chunk;
  logic [31:0]           addr_shifted;
  logic [IDX_W-1:0]      next_idx;
  logic                  is_root;
  logic                  stop_invalid;
  logic                  stop_leaf;
  logic                  stop_limit;
  logic                  stop;
  logic                  descend;
  mtpl_res_t             res_now;

  // Stride of the current level; deeper levels reuse the last register.
  always_comb begin
    stride_sel = strides[NUM_CFG-1];
    for (int i = 0; i < NUM_CFG - 1; i++) begin
      if (int'(depth) == i) begin
        stride_sel = strides[i];
      end
    end
  end

  mtpl_chunk u_chunk (
    .addr_sh    (addr_sh),
    .stride_raw (stride_sel),
    .chunk      (chunk),
    .addr_next  (addr_shifted)
  );

  assign next_idx = to_idx({1'b0, rd_node.child_base} + {1'b0, chunk});

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Node evaluation and outputs.
  always_comb begin
    is_root      = (depth == '0);
    stop_invalid = !rd_node.valid;
    stop_leaf    = rd_node.valid && rd_node.leaf;
    stop_limit   = rd_node.valid && !rd_node.leaf && (int'(depth) >= LEVELS);
    stop         = 1'b0;
    descend      = 1'b0;
    busy         = 1'b0;
    rd_addr      = '0;
    res_now.reached_leaf = stop_leaf;
    if (stop_invalid && !is_root) begin
      res_now.out_port         = cur_port;
      res_now.levels_descended = to_levels(DEPTH_W'(depth - 1'b1));
    end else begin
      res_now.out_port         = rd_node.port;
      res_now.levels_descended = to_levels(depth);
    end
    case (state)
      ST_IDLE: begin
        rd_addr = '0;
      end
      ST_EVAL: begin
        busy    = 1'b1;
        stop    = stop_invalid || stop_leaf || stop_limit;
        descend = !stop;
        rd_addr = next_idx;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      depth <= '0;
    end else begin
      state <= state_next;
      done  <= stop;
      if (go && (state == ST_IDLE)) begin
        depth <= '0;
      end else if (descend) begin
        depth <= depth + 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (go && (state == ST_IDLE)) begin
      addr_sh <= dest_address;
    end else if (descend) begin
      addr_sh  <= addr_shifted;
      cur_port <= rd_node.port;
    end
    if (stop) begin
      result <= res_now;
    end
  end

endmodule

`default_nettype wire

/* rtl/multibit_trie_port_lookup.sv */
// ----------------------------------------------------------------------------
// multibit_trie_port_lookup
// Fixed-stride multibit trie that maps an IPv4 destination address to an
// output port, with a loadable node table and per-level stride registers.
// ----------------------------------------------------------------------------
//
// Channel   Signals                          Transfer
// -------   -------------------------------  ---------------------------------
// request   start, busy, req                 start high while busy low
// result    done, result                     done high for one cycle
// config    cfg_we, cfg_index, cfg_data      cfg_we high at a rising edge
//
// A write transaction updates the node table at the edge that accepts it and
// produces no result; busy stays low, so another transaction may follow in
// the next cycle. A lookup reads one node per cycle from the table RAM, whose
// registered read port sets the pace: after the accepting edge the walk visits
// between 1 and LEVELS+1 nodes, and done is high in the cycle after the last
// one. The next transaction can be accepted in the cycle in which done is
// high. Reset clears the stride registers to their defaults and marks every
// table entry as never written. The receiver cannot stall: each result is
// valid only while done is high.
// ----------------------------------------------------------------------------
`default_nettype none

module multibit_trie_port_lookup (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire mtpl_pkg::mtpl_req_t                 req,
  output logic                                     done,
  output mtpl_pkg::mtpl_res_t                      result,
  input  wire logic                                cfg_we,
  input  wire logic [mtpl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mtpl_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import mtpl_pkg::*;

  // Stride registers, one per trie level; levels below the fourth share the
  // last one. Values above eight are saturated where they are used.
  logic [NUM_CFG-1:0][CFG_DATA_W-1:0] strides;

  logic             accept;
  logic             lookup_go;
  mtpl_wr_t         wr;
  logic [IDX_W-1:0] rd_addr;
  mtpl_node_t       rd_node;

  always_ff @(posedge clk) begin
    if (rst) begin
      strides <= STRIDE_RESET;
    end else if (cfg_we) begin
      strides[cfg_index] <= cfg_data;
    end
  end

  // A transaction is taken whenever the walk sequencer is free.
  assign accept    = start && !busy;
  assign lookup_go = accept && (req.req_type == REQ_LOOKUP);

  // Table writes go straight into the node store; the index wraps modulo
  // the table size.
  always_comb begin
    wr.en              = accept && (req.req_type == REQ_WRITE);
    wr.idx             = to_idx({1'b0, req.entry_index});
    wr.node.valid      = req.entry_valid;
    wr.node.leaf       = req.entry_leaf;
    wr.node.port       = req.entry_port;
    wr.node.child_base = req.entry_child_base;
  end

  mtpl_node_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_node (rd_node)
  );

  // The sequencer issues the root read while idle, then evaluates one node
  // per cycle and issues the read of the chosen child.
  mtpl_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .go           (lookup_go),
    .dest_address (req.dest_address),
    .strides      (strides),
    .rd_node      (rd_node),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .done         (done),
    .result       (result)
  );

`ifndef SYNTHESIS
  // A result only ever follows a cycle in which a walk was in progress.
  a_done_after_walk: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding walk");

  // A table write never produces a result.
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.req_type == REQ_WRITE)) |=> !done)
    else $error("result strobe after a table write");

  // An accepted lookup starts a walk.
  a_lookup_walks: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req.req_type == REQ_LOOKUP)) |=> (busy && !done))
    else $error("accepted lookup did not start a walk");
`endif

endmodule

`default_nettype wire

/* tb/trie_route_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// trie_route_scoreboard_pkg
// Route predictor and result scoreboard for the multibit trie port lookup.
// It mirrors the node table and the stride registers and walks the trie for
// every accepted lookup.
// ----------------------------------------------------------------------------
package trie_route_scoreboard_pkg;

  import mtpl_pkg::*;

  class trie_route_scoreboard;

    mtpl_node_t              node_table [NODES];
    logic [CFG_DATA_W-1:0]   stride_reg [NUM_CFG];
    mtpl_res_t               expected_routes [$];
    int                      mismatches;

    function new();
      for (int i = 0; i < NODES; i++) node_table[i] = '0;
      for (int i = 0; i < NUM_CFG; i++) stride_reg[i] = STRIDE_RESET[i];
      mismatches = 0;
    endfunction

    function void set_stride(input int idx, input logic [CFG_DATA_W-1:0] value);
      stride_reg[idx] = value;
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction

    // Deeper levels reuse the last register; values above eight saturate.
    function int unsigned stride_of(input int unsigned level);
      int unsigned s;
      s = stride_reg[(level < NUM_CFG) ? level : NUM_CFG - 1];
      return (s > STRIDE_MAX) ? STRIDE_MAX : s;
    endfunction

    // Address bits below bit 0 read as zero.
    function logic [7:0] address_chunk(input logic [31:0] addr, input int unsigned pos,
                                       input int unsigned width);
      logic [63:0] wide;
      if (width == 0 || pos >= 32) return '0;
      wide = {addr, 32'h0} >> (64 - pos - width);
      return wide[7:0] & 8'((16'd1 << width) - 16'd1);
    endfunction

    function mtpl_res_t predict_route(input logic [31:0] addr);
      mtpl_res_t        res;
      mtpl_node_t       node;
      logic [IDX_W-1:0] cur;
      logic [IDX_W-1:0] nxt;
      int unsigned      pos;
      int unsigned      depth;
      int unsigned      s;
      logic             leaf_hit;
      logic             stop;
      cur      = '0;
      pos      = 0;
      depth    = 0;
      leaf_hit = 1'b0;
      stop     = 1'b0;
      while (!stop) begin
        node = node_table[cur];
        if (!node.valid) begin
          stop = 1'b1;
        end else if (node.leaf) begin
          leaf_hit = 1'b1;
          stop     = 1'b1;
        end else if (depth >= LEVELS) begin
          stop = 1'b1;
        end else begin
          s   = stride_of(depth);
          nxt = node.child_base + address_chunk(addr, pos, s);
          if (!node_table[nxt].valid) begin
            stop = 1'b1;
          end else begin
            cur   = nxt;
            pos   = pos + s;
            depth = depth + 1;
          end
        end
      end
      res.out_port         = node_table[cur].port;
      res.levels_descended = 3'(depth);
      res.reached_leaf     = leaf_hit;
      return res;
    endfunction

    // Writes update the mirrored table; lookups queue their expected route.
    function void note_request(input mtpl_req_t r);
      if (r.req_type == REQ_WRITE) begin
        node_table[r.entry_index].valid      = r.entry_valid;
        node_table[r.entry_index].leaf       = r.entry_leaf;
        node_table[r.entry_index].port       = r.entry_port;
        node_table[r.entry_index].child_base = r.entry_child_base;
      end else begin
        expected_routes.push_back(predict_route(r.dest_address));
      end
    endfunction

    task report(input string what);
      if (mismatches < 100) $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_route(input mtpl_res_t got);
      mtpl_res_t exp;
      if (expected_routes.size() == 0) begin
        report("result strobe with no lookup outstanding");
      end else begin
        exp = expected_routes.pop_front();
        if (got.out_port !== exp.out_port)
          report($sformatf("out_port got %0d expected %0d", got.out_port, exp.out_port));
        if (got.levels_descended !== exp.levels_descended)
          report($sformatf("levels_descended got %0d expected %0d",
                           got.levels_descended, exp.levels_descended));
        if (got.reached_leaf !== exp.reached_leaf)
          report($sformatf("reached_leaf got %0d expected %0d",
                           got.reached_leaf, exp.reached_leaf));
      end
    endtask

    task report_leftovers();
      while (expected_routes.size() != 0) begin
        void'(expected_routes.pop_front());
        report("lookup never produced a result");
      end
    endtask

  endclass

endpackage

/* tb/tb_multibit_trie_port_lookup.sv */
// ----------------------------------------------------------------------------
// tb_multibit_trie_port_lookup
// Self-checking testbench for the multibit trie port lookup.
// A short directed sequence covers empty and invalid roots, leaf roots, index
// wrap, invalid children, the level limit and stride saturation; then six
// phases each set the strides, load a random table (in full in the first
// phase, a few random entries and the root in the later ones) and run random
// lookups under different amounts of sender idling. Every result is compared
// against a route predicted from a mirrored copy of the table.
// ----------------------------------------------------------------------------
module tb_multibit_trie_port_lookup;

  timeunit 1ns;
  timeprecision 1ps;

  import mtpl_pkg::*;
  import trie_route_scoreboard_pkg::*;

  // Writes finish at their own edge.
  localparam int SETTLE_CYCLES     = LEVELS + 4;
  localparam int PHASES            = 6;
  localparam int LOOKUPS_PER_PHASE = 35;
  localparam int PHASE_UPDATES     = 24;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  mtpl_req_t             req;
  logic                  done;
  mtpl_res_t             result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Percentage chance, per cycle, that the sender inserts an idle cycle.
  int idle_pct;

  trie_route_scoreboard routes = new();

  multibit_trie_port_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs; the normal run takes well under 100 us.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // The result strobe lasts one cycle and cannot be held off, so every edge
  // with done high delivers one result transaction.
  always @(posedge clk) begin
    if (!rst && done) routes.check_route(result);
  end

  // Fills every field with random bits so that unused fields toggle too.
  function automatic mtpl_req_t random_req();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[$bits(mtpl_req_t)-1:0];
  endfunction

  function automatic mtpl_req_t lookup_req(input logic [31:0] addr);
    mtpl_req_t r;
    r              = random_req();
    r.req_type     = REQ_LOOKUP;
    r.dest_address = addr;
    return r;
  endfunction

  function automatic mtpl_req_t node_req(input logic [7:0] idx, input logic [6:0] port,
                                         input logic leaf, input logic valid,
                                         input logic [7:0] base);
    mtpl_req_t r;
    r                  = random_req();
    r.req_type         = REQ_WRITE;
    r.entry_index      = idx;
    r.entry_port       = port;
    r.entry_leaf       = leaf;
    r.entry_valid      = valid;
    r.entry_child_base = base;
    return r;
  endfunction

  // Geometric idle length; the cap keeps a run of bad luck short.
  function automatic int draw_gap();
    int g;
    g = 0;
    while ($urandom_range(0, 99) < idle_pct && g < 20) g++;
    return g;
  endfunction

  // Offers one transaction after an optional idle gap and waits for the edge
  // that accepts it. The previous transaction leaves start high, so with no
  // gap the next one follows back to back. busy is read just after the edge,
  // which gives the value that the block presented during the cycle before.
  task automatic send_request(input mtpl_req_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    routes.note_request(r);
  endtask

  // Stops offering transactions until every outstanding lookup has returned,
  // then lets a few more cycles pass. At least one edge always passes, so
  // start is never lowered and raised in the same time step.
  task automatic hold_until_drained(input int settle);
    start <= 1'b0;
    do @(posedge clk); while (routes.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Stride registers may only change while the block is idle.
  task automatic load_strides(input logic [NUM_CFG-1:0][CFG_DATA_W-1:0] strides);
    hold_until_drained(SETTLE_CYCLES);
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= strides[i];
      @(posedge clk);
      routes.set_stride(i, strides[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly legal strides, with the occasional zero or saturating value.
  function automatic logic [CFG_DATA_W-1:0] draw_stride();
    if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 1) != 0) ? 4'd15 : 4'd0;
    return CFG_DATA_W'($urandom_range(1, STRIDE_MAX));
  endfunction

  initial begin
    logic [NUM_CFG-1:0][CFG_DATA_W-1:0] strides;
    int                                 valid_pct;
    int                                 leaf_pct;
    logic                               root_plain;
    int                                 n_writes;
    int                                 node_idx;

    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    idle_pct  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---------------- Directed part, reset strides 5/2/2/3 ----------------
    // An empty table: the root is invalid and its zero port comes back.
    send_request(lookup_req(32'h0000_0000), 0);
    // An invalid root ignores its leaf flag but still returns its port.
    send_request(node_req(8'd0, 7'd127, 1'b1, 1'b0, 8'd255), 0);
    send_request(lookup_req(32'hFFFF_FFFF), 0);
    // A valid leaf root stops the walk at once and reports a leaf.
    send_request(node_req(8'd0, 7'd0, 1'b1, 1'b1, 8'd0), 0);
    send_request(lookup_req(32'hFFFF_FFFF), 0);
    // A two-level path built on index wrap: 250+31 wraps to 25 and 255+3 to 2.
    send_request(node_req(8'd0, 7'd1, 1'b0, 1'b1, 8'd250), 0);
    send_request(node_req(8'd25, 7'd2, 1'b0, 1'b1, 8'd255), 0);
    send_request(node_req(8'd2, 7'd3, 1'b1, 1'b1, 8'd0), 0);
    send_request(node_req(8'd255, 7'd126, 1'b0, 1'b0, 8'd0), 0);
    send_request(lookup_req(32'hFFFF_FFFF), 0);
    // Second chunk of zero points at the invalid top entry: stop at level one.
    send_request(lookup_req(32'hF800_0000), 0);
    // First chunk of zero points at an unwritten entry: stop at the root.
    send_request(lookup_req(32'h0000_0000), 0);

    // Zero strides keep the chunk at zero, so a root whose children start at
    // itself descends into itself until the level limit stops the walk.
    load_strides({4'd0, 4'd0, 4'd0, 4'd0});
    send_request(node_req(8'd0, 7'd127, 1'b0, 1'b1, 8'd0), 0);
    send_request(lookup_req(32'hFFFF_FFFF), 0);
    // Only the last level consumes bits, with a saturating stride: the walk
    // reaches a leaf exactly at the level limit, or misses at the last level.
    send_request(node_req(8'd171, 7'd99, 1'b1, 1'b1, 8'd0), 0);
    load_strides({4'd15, 4'd0, 4'd0, 4'd0});
    send_request(lookup_req(32'hAB00_0000), 0);
    send_request(lookup_req(32'hAC00_0000), 0);
    // All strides saturated to eight bits; a zero address loops on the root.
    load_strides({4'd15, 4'd15, 4'd15, 4'd15});
    send_request(lookup_req(32'h0000_0000), 0);
    send_request(lookup_req(32'h00AB_0000), 0);

    // ---------------- Random phases ----------------
    // Each phase sets the strides, writes random table content and then runs
    // random lookups with some stray transactions. The first phase rebuilds
    // the whole table; later phases rewrite a few random entries and the root.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          strides   = STRIDE_RESET;
          idle_pct  = 0;
          valid_pct = 90;
          leaf_pct  = 10;
        end
        1: begin
          strides   = {4'd8, 4'd8, 4'd8, 4'd8};
          idle_pct  = 65;
          valid_pct = 85;
          leaf_pct  = 15;
        end
        2: begin
          strides   = {4'd1, 4'd1, 4'd1, 4'd1};
          idle_pct  = 37;
          valid_pct = 90;
          leaf_pct  = 5;
        end
        3: begin
          strides   = {draw_stride(), draw_stride(), draw_stride(), draw_stride()};
          idle_pct  = 0;
          valid_pct = 50;
          leaf_pct  = 30;
        end
        4: begin
          strides   = {draw_stride(), draw_stride(), draw_stride(), draw_stride()};
          idle_pct  = 65;
          valid_pct = 80;
          leaf_pct  = 15;
        end
        default: begin
          strides   = {draw_stride(), draw_stride(), draw_stride(), draw_stride()};
          idle_pct  = 37;
          valid_pct = 95;
          leaf_pct  = 10;
        end
      endcase
      load_strides(strides);

      // The root is written last and is usually a valid inner node, so most
      // lookups get past the first level.
      n_writes = (ph == 0) ? NODES : PHASE_UPDATES;
      for (int n = n_writes - 1; n >= 0; n--) begin
        if (n == 0) begin
          node_idx = 0;
        end else if (ph == 0) begin
          node_idx = n;
        end else begin
          node_idx = int'($urandom_range(1, NODES - 1));
        end
        root_plain = (node_idx == 0) && ($urandom_range(0, 19) != 0);
        send_request(node_req(8'(node_idx), 7'($urandom_range(0, 127)),
                              root_plain ? 1'b0 : ($urandom_range(0, 99) < leaf_pct),
                              root_plain ? 1'b1 : ($urandom_range(0, 99) < valid_pct),
                              8'($urandom_range(0, 255))),
                     draw_gap());
      end

      for (int k = 0; k < LOOKUPS_PER_PHASE; k++) begin
        // Stray transactions of either kind with fully random content.
        if ($urandom_range(0, 9) == 0) send_request(random_req(), draw_gap());
        // Now and then the sender waits until all results are back.
        if ($urandom_range(0, 49) == 0) hold_until_drained(0);
        send_request(lookup_req($urandom()), draw_gap());
      end
    end

    // ---------------- Wind-down ----------------
    start <= 1'b0;
    for (int w = 0; w < 2000 && routes.pending() != 0; w++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    routes.report_leftovers();
    if (routes.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
